@@ sv/rdq_pkg.sv @@
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared types and constants for the reversible deque: item, result and
// command types, back-end states, operation and status codes, storage sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package rdq_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int SUM_W    = ADDR_W + 1;
    localparam int DATA_W   = 32;
    localparam int CQ_DEPTH = 4;
    localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

    localparam logic [2:0] FUNC_PUSH_FRONT = 3'd0;
    localparam logic [2:0] FUNC_PUSH_BACK  = 3'd1;
    localparam logic [2:0] FUNC_POP_FRONT  = 3'd2;
    localparam logic [2:0] FUNC_POP_BACK   = 3'd3;

    localparam logic [1:0] STATUS_POPPED = 2'd0;
    localparam logic [1:0] STATUS_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_FULL   = 2'd2;

    typedef struct packed {
        logic [2:0]               func;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] popped_value;
        logic [1:0]               status;
    } out_item_t;

    typedef enum logic {
        CMD_PUT,
        CMD_TAKE
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              at_head;
        logic [DATA_W-1:0] value;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } back_state_t;

endpackage

`default_nettype wire

@@ sv/reversible_deque_top.sv @@
// ----------------------------------------------------------------------------
// reversible_deque_top
// Double-ended queue of signed 32-bit values in a ring buffer with a
// reverse flag; front end decodes and queues commands, back end runs them.
//
//   channel   direction  handshake             payload
//   item      in         push / full           func, value
//   result    out        empty / pop           popped_value, status
//
// A reverse is absorbed by the front end and never reaches the back end.
// A push, or a pop on an empty queue, completes in ST_IDLE; a pop that
// returns a value also passes through ST_READ (registered memory read).
// The back end starts a command only when the result register is free or
// being popped; the 4-entry command queue keeps taking items meanwhile until full.
// Reset clears pointers, counts and flag; the entry memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module reversible_deque_top
    import rdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          empty,
    input  wire logic     pop,
    output out_item_t     result
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    rdq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rdq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

`default_nettype wire

@@ sv/rdq_front.sv @@
// ----------------------------------------------------------------------------
// rdq_front
// Accepts items, tracks the reverse flag, maps logical ends to physical
// ends and queues the resulting commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_front
    import rdq_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    output logic          full,
    input  wire in_item_t item,
    output logic          cmd_valid,
    input  wire logic     cmd_ready,
    output cmd_t          cmd
);

    cmd_t                q_reg [CQ_DEPTH];
    logic [CQ_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CQ_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_CNT_W-1:0] count_reg, count_next;
    logic                reversed_reg, reversed_next;
    logic                accept;
    logic                enq;
    logic                deq;
    cmd_t                new_cmd;

    assign full      = (count_reg == CQ_CNT_W'(CQ_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign accept    = push && !full;
    assign deq       = cmd_valid && cmd_ready;

    always_comb
    begin
        new_cmd.value   = item.value;
        new_cmd.kind    = CMD_PUT;
        new_cmd.at_head = 1'b0;
        enq             = 1'b0;
        reversed_next   = reversed_reg;
        unique case (item.func)
            FUNC_PUSH_FRONT:
            begin
                new_cmd.kind    = CMD_PUT;
                new_cmd.at_head = !reversed_reg;
                enq             = accept;
            end
            FUNC_PUSH_BACK:
            begin
                new_cmd.kind    = CMD_PUT;
                new_cmd.at_head = reversed_reg;
                enq             = accept;
            end
            FUNC_POP_FRONT:
            begin
                new_cmd.kind    = CMD_TAKE;
                new_cmd.at_head = !reversed_reg;
                enq             = accept;
            end
            FUNC_POP_BACK:
            begin
                new_cmd.kind    = CMD_TAKE;
                new_cmd.at_head = reversed_reg;
                enq             = accept;
            end
            default:
            begin
                // every other code flips the ends
                if (accept)
                begin
                    reversed_next = !reversed_reg;
                end
            end
        endcase
    end

    always_comb
    begin
        wr_ptr_next = enq ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = deq ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            reversed_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            reversed_reg <= reversed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            q_reg[wr_ptr_reg] <= new_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/rdq_back.sv @@
// ----------------------------------------------------------------------------
// rdq_back
// Executes physical head/tail commands on the ring buffer and holds the
// result register toward the output side.
// ----------------------------------------------------------------------------
`default_nettype none

module rdq_back
    import rdq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_ready,
    input  wire cmd_t      cmd,
    output logic           empty,
    input  wire logic      pop,
    output out_item_t      result
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    back_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] first_reg, first_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              res_valid_reg, res_valid_next;
    out_item_t         res_reg, res_next;

    logic              wr_en;
    logic              rd_en;
    logic [ADDR_W-1:0] mem_addr;

    logic [ADDR_W-1:0] first_dec;
    logic [ADDR_W-1:0] first_inc;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  last_sum;
    logic [ADDR_W-1:0] tail_addr;
    logic [ADDR_W-1:0] last_addr;
    logic              is_full;
    logic              is_empty;
    logic              res_free;

    assign empty    = !res_valid_reg;
    assign result   = res_reg;
    assign res_free = !res_valid_reg || pop;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    assign first_dec = (first_reg == '0) ? ADDR_W'(DEPTH - 1) : first_reg - 1'b1;
    assign first_inc = (first_reg == ADDR_W'(DEPTH - 1)) ? '0 : first_reg + 1'b1;
    assign tail_sum  = SUM_W'(first_reg) + SUM_W'(count_reg);
    assign last_sum  = tail_sum - 1'b1;
    assign tail_addr = (tail_sum >= SUM_W'(DEPTH)) ?
                       ADDR_W'(tail_sum - SUM_W'(DEPTH)) : ADDR_W'(tail_sum);
    assign last_addr = (last_sum >= SUM_W'(DEPTH)) ?
                       ADDR_W'(last_sum - SUM_W'(DEPTH)) : ADDR_W'(last_sum);

    always_comb
    begin
        state_next     = state_reg;
        first_next     = first_reg;
        count_next     = count_reg;
        res_valid_next = res_valid_reg && !pop;
        res_next       = res_reg;
        cmd_ready      = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        mem_addr       = cmd.at_head ? first_dec : tail_addr;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid && res_free)
                begin
                    cmd_ready = 1'b1;
                    unique case (cmd.kind)
                        CMD_PUT:
                        begin
                            if (is_full)
                            begin
                                res_valid_next        = 1'b1;
                                res_next.popped_value = '0;
                                res_next.status       = STATUS_FULL;
                            end
                            else
                            begin
                                wr_en      = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (cmd.at_head)
                                begin
                                    first_next = first_dec;
                                end
                            end
                        end
                        CMD_TAKE:
                        begin
                            mem_addr = cmd.at_head ? first_reg : last_addr;
                            if (is_empty)
                            begin
                                res_valid_next        = 1'b1;
                                res_next.popped_value = '0;
                                res_next.status       = STATUS_EMPTY;
                            end
                            else
                            begin
                                rd_en      = 1'b1;
                                count_next = count_reg - 1'b1;
                                state_next = ST_READ;
                                if (cmd.at_head)
                                begin
                                    first_next = first_inc;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                // result register was free when the read was issued
                res_valid_next        = 1'b1;
                res_next.popped_value = rd_data_reg;
                res_next.status       = STATUS_POPPED;
                state_next            = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            first_reg     <= '0;
            count_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            first_reg     <= first_next;
            count_reg     <= count_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[mem_addr] <= cmd.value;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[mem_addr];
        end
    end

endmodule

`default_nettype wire
